[rtl/core/assert_macros.svh]
// Assertion shorthands for the resampler checkers.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define NNR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nnr assertion failed");

// Next-cycle implication.
`define NNR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nnr assertion failed");

`endif

[rtl/core/nnr_pkg.sv]
package nnr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 18;
  localparam int GAIN_W     = 18;
  localparam int PHASE_W    = 19;
  localparam int WORD_W     = 32;
  localparam int PROD_W     = 35;
  localparam int MAG_W      = 34;
  localparam int EXP_W      = 6;
  localparam int MANT_W     = 24;
  localparam int FRAC_W     = 23;
  localparam int EXPF_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;
  localparam int DIV_CNT_W  = $clog2(RATE_W + 1);

  // float32 exponent field = msb position of the product + 127 - 31
  localparam logic [EXPF_W-1:0] FLT_EXP_OFS = 8'd96;

  localparam logic [RATE_W-1:0] SOURCE_RATE_RST = 18'd48000;
  localparam logic [RATE_W-1:0] TARGET_RATE_RST = 18'd48000;
  localparam logic [GAIN_W-1:0] GAIN_RST        = 18'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_RATE   = 3'd0,
    CFG_TARGET_RATE   = 3'd1,
    CFG_STEREO_SOURCE = 3'd2,
    CFG_FLOAT_OUTPUT  = 3'd3,
    CFG_GAIN          = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ABS,
    ST_NORM,
    ST_PACK,
    ST_EMIT
  } nnr_state_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic abs_load;
    logic norm;
    logic pack;
    logic emit;
  } nnr_cmd_t;

  typedef struct packed {
    logic skip;
    logic work_done;
    logic out_free;
    logic last_one;
  } nnr_sts_t;

endpackage

[rtl/core/nnr_div.sv]
module nnr_div import nnr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RATE_W-1:0] dividend,
  input  logic [RATE_W-1:0] divisor,
  output logic              busy,
  output logic [RATE_W-1:0] quot,
  output logic [RATE_W-1:0] rem
);

  logic [RATE_W-1:0]    n_r, n_nxt;
  logic [RATE_W-1:0]    d_r, d_nxt;
  logic [RATE_W-1:0]    rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] iter_r, iter_nxt;
  logic [RATE_W:0]      trial;
  logic [RATE_W:0]      diff;
  logic                 ge;

  assign trial = {rem_r, n_r[RATE_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = (trial >= {1'b0, d_r});
  assign busy  = (iter_r != '0);
  assign quot  = n_r;
  assign rem   = rem_r;

  // Restoring division, one quotient bit per cycle, MSB first.
  always_comb begin
    n_nxt    = n_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    iter_nxt = iter_r;
    if (start) begin
      n_nxt    = dividend;
      d_nxt    = divisor;
      rem_nxt  = '0;
      iter_nxt = DIV_CNT_W'(RATE_W);
    end else if (busy) begin
      rem_nxt  = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
      n_nxt    = {n_r[RATE_W-2:0], ge};
      iter_nxt = iter_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else begin
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

endmodule

[rtl/core/nnr_dp.sv]
module nnr_dp import nnr_pkg::*; #(
  parameter int MAX_RUN = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [SAMPLE_W-1:0]  left_sample,
  input  logic signed [SAMPLE_W-1:0]  right_sample,
  input  nnr_cmd_t                    cmd,
  output nnr_sts_t                    sts,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [WORD_W-1:0]           out_tdata,
  output logic                        out_tlast
);

  localparam int CNT_W = $clog2(MAX_RUN + 1);

  // configuration
  logic [RATE_W-1:0] src_r, src_nxt;
  logic [RATE_W-1:0] tgt_r, tgt_nxt;
  logic              stereo_r, stereo_nxt;
  logic              float_r, float_nxt;
  logic [GAIN_W-1:0] gain_r, gain_nxt;

  logic [PHASE_W-1:0]              phase_r, phase_nxt;
  logic signed [SAMPLE_W-1:0]      s_r, s_nxt;
  logic signed [PROD_W-1:0]        prod_r, prod_nxt;
  logic [MAG_W-1:0]                mag_r, mag_nxt;
  logic [EXP_W-1:0]                exp_r, exp_nxt;
  logic [WORD_W-1:0]               word_r, word_nxt;
  logic [CNT_W-1:0]                cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]               out_data_r, out_data_nxt;
  logic                            out_last_r, out_last_nxt;

  logic [RATE_W-1:0]          src_eff, tgt_eff;
  logic                       skip;
  logic                       div_busy;
  logic [RATE_W-1:0]          div_quot, div_rem;
  logic [RATE_W-1:0]          div_dividend;
  logic signed [SAMPLE_W:0]   lr_sum, lr_adj;
  logic signed [PROD_W-1:0]   s_ext, gain_ext;
  logic                       norm_done;
  logic signed [PROD_W-1:0]   biased;
  logic signed [PROD_W-17:0]  q16;
  logic [SAMPLE_W-1:0]        i16;
  logic [WORD_W-1:0]          int_word;
  logic [MANT_W-1:0]          mant;
  logic                       rnd_up;
  logic [MANT_W:0]            mant_rnd;
  logic [FRAC_W-1:0]          frac;
  logic [EXPF_W-1:0]          exp_field;
  logic [WORD_W-1:0]          flt_word;

  assign src_eff = (src_r == '0) ? RATE_W'(1) : src_r;
  assign tgt_eff = (tgt_r == '0) ? RATE_W'(1) : tgt_r;
  assign skip    = (phase_r >= {1'b0, tgt_eff});

  assign div_dividend = RATE_W'({1'b0, tgt_eff} - phase_r - PHASE_W'(1));

  // ceil((tgt - r) / src) = floor((tgt - r - 1) / src) + 1
  nnr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.accept && !skip),
    .dividend (div_dividend),
    .divisor  (src_eff),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign lr_sum   = {left_sample[SAMPLE_W-1], left_sample} +
                    {right_sample[SAMPLE_W-1], right_sample};
  assign lr_adj   = lr_sum + (SAMPLE_W+1)'(lr_sum[SAMPLE_W]);
  assign s_ext    = PROD_W'(s_r);
  assign gain_ext = PROD_W'({1'b0, gain_r});

  assign norm_done = mag_r[MAG_W-1] || (mag_r == '0);

  // int16: truncate toward zero, then saturate
  assign biased = prod_r + (prod_r[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
  assign q16    = biased[PROD_W-1:16];
  always_comb begin
    if (q16 > (PROD_W-16)'(32767)) begin
      i16 = 16'h7FFF;
    end else if (q16 < -(PROD_W-16)'(32768)) begin
      i16 = 16'h8000;
    end else begin
      i16 = q16[SAMPLE_W-1:0];
    end
  end
  assign int_word = {{(WORD_W-SAMPLE_W){i16[SAMPLE_W-1]}}, i16};

  // float32: round to nearest even on the normalized magnitude
  assign mant      = mag_r[MAG_W-1 -: MANT_W];
  assign rnd_up    = mag_r[MAG_W-MANT_W-1] &&
                     ((|mag_r[MAG_W-MANT_W-2:0]) || mag_r[MAG_W-MANT_W]);
  assign mant_rnd  = {1'b0, mant} + (MANT_W+1)'(rnd_up);
  assign frac      = mant_rnd[MANT_W] ? mant_rnd[FRAC_W:1] : mant_rnd[FRAC_W-1:0];
  assign exp_field = EXPF_W'(exp_r) + FLT_EXP_OFS + EXPF_W'(mant_rnd[MANT_W]);
  assign flt_word  = (prod_r == '0) ? {s_r[SAMPLE_W-1], {(WORD_W-1){1'b0}}}
                                    : {s_r[SAMPLE_W-1], exp_field, frac};

  always_comb begin
    src_nxt    = src_r;
    tgt_nxt    = tgt_r;
    stereo_nxt = stereo_r;
    float_nxt  = float_r;
    gain_nxt   = gain_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SOURCE_RATE:   src_nxt    = cfg_data[RATE_W-1:0];
        CFG_TARGET_RATE:   tgt_nxt    = cfg_data[RATE_W-1:0];
        CFG_STEREO_SOURCE: stereo_nxt = cfg_data[0];
        CFG_FLOAT_OUTPUT:  float_nxt  = cfg_data[0];
        CFG_GAIN:          gain_nxt   = cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    s_nxt         = s_r;
    prod_nxt      = prod_r;
    mag_nxt       = mag_r;
    exp_nxt       = exp_r;
    word_nxt      = word_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;

    if (cmd.accept) begin
      s_nxt = stereo_r ? lr_adj[SAMPLE_W:1] : left_sample;
      if (skip) begin
        phase_nxt = phase_r - {1'b0, tgt_eff};
      end
    end
    if (cmd.mul) begin
      prod_nxt = PROD_W'(s_ext * gain_ext);
    end
    if (cmd.abs_load) begin
      mag_nxt = prod_r[PROD_W-1] ? MAG_W'(-prod_r) : MAG_W'(prod_r);
      exp_nxt = EXP_W'(MAG_W - 1);
    end
    if (cmd.norm && !norm_done) begin
      if (mag_r[MAG_W-1 -: 8] == '0) begin
        mag_nxt = {mag_r[MAG_W-9:0], 8'd0};
        exp_nxt = exp_r - EXP_W'(8);
      end else begin
        mag_nxt = {mag_r[MAG_W-2:0], 1'b0};
        exp_nxt = exp_r - EXP_W'(1);
      end
    end
    if (cmd.pack) begin
      word_nxt  = float_r ? flt_word : int_word;
      phase_nxt = PHASE_W'(src_eff - div_rem - RATE_W'(1));
      cnt_nxt   = (div_quot >= RATE_W'(MAX_RUN)) ? CNT_W'(MAX_RUN)
                                                 : CNT_W'(div_quot + RATE_W'(1));
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = word_r;
      out_last_nxt  = (cnt_r == CNT_W'(1));
      cnt_nxt       = cnt_r - CNT_W'(1);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r       <= SOURCE_RATE_RST;
      tgt_r       <= TARGET_RATE_RST;
      stereo_r    <= 1'b0;
      float_r     <= 1'b0;
      gain_r      <= GAIN_RST;
      phase_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      src_r       <= src_nxt;
      tgt_r       <= tgt_nxt;
      stereo_r    <= stereo_nxt;
      float_r     <= float_nxt;
      gain_r      <= gain_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    prod_r     <= prod_nxt;
    mag_r      <= mag_nxt;
    exp_r      <= exp_nxt;
    word_r     <= word_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.skip      = skip;
  assign sts.work_done = norm_done && !div_busy;
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.last_one  = (cnt_r == CNT_W'(1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/core/nnr_ctrl.sv]
module nnr_ctrl import nnr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  nnr_sts_t sts,
  output nnr_cmd_t cmd
);

  nnr_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid && !sts.skip) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL:  state_nxt = ST_ABS;
      ST_ABS:  state_nxt = ST_NORM;
      ST_NORM: begin
        if (sts.work_done) begin
          state_nxt = ST_PACK;
        end
      end
      ST_PACK: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free && sts.last_one) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_MUL:  cmd.mul      = 1'b1;
      ST_ABS:  cmd.abs_load = 1'b1;
      ST_NORM: cmd.norm     = 1'b1;
      ST_PACK: cmd.pack     = 1'b1;
      ST_EMIT: cmd.emit     = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/core/nearest_neighbor_resampler_core.sv]
// Nearest-neighbor sample rate converter. Each input transfer carries one PCM
// frame; stereo frames are averaged (truncated toward zero), mono frames use
// the left sample. The frame then produces every output frame whose nearest
// source index it is, zero up to MAX_RUN of them, each scaled by the Q16 gain
// and given as a saturated int16 or as float32 bits, with tlast on the final
// one of the run. An input that owns no output is taken without leaving idle;
// one that owns outputs passes the multiply, magnitude, normalize (waiting
// also for the 18-step serial divider that works out the run length) and pack
// states, then yields one output frame per cycle while the sink keeps up; the
// next input is taken as soon as the last result of the run sits in the output
// register. Rates and gain may be written only while the block is idle.
module nearest_neighbor_resampler_core import nnr_pkg::*; #(
  parameter int MAX_RUN = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input frame stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [15:0] left_sample, [31:16] right_sample
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [WORD_W-1:0]     out_tdata,  // [31:0] sample_word
  output logic                  out_tlast,  // run_last
  // register writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  nnr_cmd_t cmd;
  nnr_sts_t sts;

  // Sequence one frame: take it, multiply, normalize, pack, then emit the run.
  nnr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the registers, phase remainder, arithmetic and the output register.
  nnr_dp #(
    .MAX_RUN (MAX_RUN)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_sample  ($signed(in_tdata[15:0])),
    .right_sample ($signed(in_tdata[31:16])),
    .cmd          (cmd),
    .sts          (sts),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast)
  );

endmodule

[rtl/core/nnr_checker.sv]
`include "assert_macros.svh"

module nnr_checker import nnr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [WORD_W-1:0] out_tdata,
  input logic              out_tlast
);

  // stalled result stays offered and unchanged
  `NNR_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `NNR_ASSERT_NEXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tlast))
  // a run is delivered without gaps once the sink keeps up
  `NNR_ASSERT_NEXT(a_run_gapless, out_tvalid && out_tready && !out_tlast, out_tvalid)
  // no new frame is taken while a run is still being emitted
  `NNR_ASSERT_IMPL(a_no_take_mid_run, out_tvalid && !out_tlast, !in_tready)

endmodule

bind nearest_neighbor_resampler_core nnr_checker u_nnr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
